FILE: hw/rtl/stlu_pkg.sv
// ----------------------------------------------------------------------------
// stlu_pkg
// Shared types and constants of the shuffled triple-LCG uniform generator.
// ----------------------------------------------------------------------------
package stlu_pkg;

  // Datapath widths of the shared modular unit.
  localparam int ACC_W = 32;
  localparam int MUL_W = 14;
  localparam int INC_W = 18;
  localparam int MOD_W = 20;
  localparam int QUO_W = 13;
  localparam int RCP_W = 16;

  // Width of the three generators and of a table entry.
  localparam int GEN_A_W = 20;
  localparam int GEN_B_W = 18;
  localparam int GEN_P_W = 18;
  localparam int SEED_W  = 31;
  localparam int ENTRY_W = GEN_A_W + GEN_B_W;

  // Generator a.
  localparam logic [MOD_W-1:0] MOD_A = 20'd714025;
  localparam logic [MUL_W-1:0] MUL_A = 14'd1366;
  localparam logic [INC_W-1:0] INC_A = 18'd150889;
  // Generator b.
  localparam logic [MOD_W-1:0] MOD_B = 20'd243000;
  localparam logic [MUL_W-1:0] MUL_B = 14'd4561;
  localparam logic [INC_W-1:0] INC_B = 18'd51349;
  // Pick generator.
  localparam logic [MOD_W-1:0] MOD_P = 20'd134456;
  localparam logic [MUL_W-1:0] MUL_P = 14'd8121;
  localparam logic [INC_W-1:0] INC_P = 18'd28411;

  // Reciprocals floor(2^32 / modulus). For any 32-bit value the quotient
  // estimated with them is the true quotient or one less.
  localparam logic [RCP_W-1:0] RCP_A = RCP_W'((64'd1 << ACC_W) / 64'(MOD_A));
  localparam logic [RCP_W-1:0] RCP_B = RCP_W'((64'd1 << ACC_W) / 64'(MOD_B));
  localparam logic [RCP_W-1:0] RCP_P = RCP_W'((64'd1 << ACC_W) / 64'(MOD_P));

  // 1504 * 714025: added to (150889 - seed) so the value is never negative.
  localparam logic [ACC_W-1:0] SEED_BIAS = 32'd1073893600;

  // Operands of one job for the shared unit: (x * mul + inc) mod modulus.
  typedef struct packed {
    logic [ACC_W-1:0] x;
    logic [MUL_W-1:0] mul;
    logic [INC_W-1:0] inc;
    logic [MOD_W-1:0] modulus;
    logic [RCP_W-1:0] recip;
  } lcg_op_t;

  // Status and result of the shared unit.
  typedef struct packed {
    logic             busy;
    logic             done;
    logic [MOD_W-1:0] rem;
    logic [QUO_W-1:0] quo;
  } lcg_res_t;

endpackage

FILE: hw/rtl/stlu_if.sv
// ----------------------------------------------------------------------------
// stlu_in_if / stlu_out_if
// Valid/ready channels that carry commands in and random words out.
// ----------------------------------------------------------------------------
interface stlu_in_if;
  logic              valid;
  logic              ready;
  logic              command;
  logic signed [30:0] seed;

  modport source (output valid, output command, output seed, input ready);
  modport sink   (input valid, input command, input seed, output ready);
endinterface

interface stlu_out_if;
  logic        valid;
  logic        ready;
  logic [19:0] coarse;
  logic [17:0] fine;
  logic        reseeded;

  modport source (output valid, output coarse, output fine, output reseeded, input ready);
  modport sink   (input valid, input coarse, input fine, input reseeded, output ready);
endinterface

FILE: hw/rtl/stlu_ram.sv
// ----------------------------------------------------------------------------
// stlu_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module stlu_ram #(
  parameter int WIDTH = 38,
  parameter int DEPTH = 107,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/stlu_lcg_unit.sv
// ----------------------------------------------------------------------------
// stlu_lcg_unit
// Shared multiply-add and reciprocal modular reduction, one job at a time.
// ----------------------------------------------------------------------------
module stlu_lcg_unit
  import stlu_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  lcg_op_t  op,
  output lcg_res_t res
);

  typedef enum logic [1:0] {U_IDLE, U_EST, U_BACK, U_FIX} ustate_t;

  localparam int EST_W = ACC_W + RCP_W;

  ustate_t          state;
  logic [ACC_W-1:0] acc;
  logic [MOD_W-1:0] modulus;
  logic [RCP_W-1:0] recip;
  logic [QUO_W-1:0] quo;
  logic             done;
  logic [ACC_W-1:0] product;
  logic [EST_W-1:0] est_full;
  logic [ACC_W-1:0] back_prod;
  logic             over;

  // The multiply-add result is always below 2^32 for the operands used.
  assign product   = ACC_W'(op.x * op.mul) + ACC_W'(op.inc);
  // Quotient estimate: the true quotient or one less.
  assign est_full  = EST_W'(acc) * EST_W'(recip);
  assign back_prod = ACC_W'(quo) * ACC_W'(modulus);
  assign over      = (acc >= ACC_W'(modulus));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= U_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == U_FIX);
      case (state)
        U_IDLE: begin
          if (start) begin
            acc     <= product;
            modulus <= op.modulus;
            recip   <= op.recip;
            state   <= U_EST;
          end
        end
        U_EST: begin
          quo   <= est_full[ACC_W +: QUO_W];
          state <= U_BACK;
        end
        U_BACK: begin
          // What is left is below twice the modulus.
          acc   <= acc - back_prod;
          state <= U_FIX;
        end
        U_FIX: begin
          if (over) begin
            acc <= acc - ACC_W'(modulus);
            quo <= quo + QUO_W'(1);
          end
          state <= U_IDLE;
        end
        default: state <= U_IDLE;
      endcase
    end
  end

  assign res.busy = (state != U_IDLE);
  assign res.done = done;
  assign res.rem  = acc[MOD_W-1:0];
  assign res.quo  = quo;

endmodule

FILE: hw/rtl/shuffled_triple_lcg_uniform_rng_unit.sv
// ----------------------------------------------------------------------------
// shuffled_triple_lcg_uniform_rng_unit
// Uniform random generator: three LCGs feeding a shuffle table.
// ----------------------------------------------------------------------------
// A draw word (command 0) returns one exact value (coarse + fine/243000)/714025
// taken from a shuffle table of TABLE_DEPTH entries, and refills that entry
// from generators a and b; the pick generator chooses the entry. A restart word
// (command 1) returns nothing and only arms a reseed for the next draw. A draw
// reseeds first if its seed is negative or the block is unseeded, and then
// flags reseeded in its result; during a reseed every table entry gets a fine
// part of zero. All modular arithmetic runs through one shared unit that does a
// multiply-add, a reciprocal quotient estimate, a back-multiply and one
// correcting subtract. An ordinary draw is four jobs (pick, a, b, table index)
// plus a table read and an output step. A reseed adds 5 + 2*TABLE_DEPTH jobs.
// A draw waits in its output step while the output register is still full and
// not being taken.
// The block accepts a new word only while its sequencer is idle; a finished
// result may still wait in the output register when the next word is taken.
// ----------------------------------------------------------------------------
module shuffled_triple_lcg_uniform_rng_unit
  import stlu_pkg::*;
#(
  parameter int TABLE_DEPTH = 107
) (
  input  logic              clk,
  input  logic              rst,
  stlu_in_if.sink           in_ch,
  stlu_out_if.source        out_ch
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  // One state per job of the shared unit, in the order the jobs run, plus idle, read and output states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_SEED,     // reduce (150889 - seed) mod 714025
    S_A1,       // first step of generator a
    S_BMOD,     // generator b from generator a
    S_A2,       // second step of generator a
    S_PMOD,     // pick generator from generator a
    S_FILL_B,   // table fill: step b
    S_FILL_A,   // table fill: step a and write the entry
    S_PICK,     // draw: step pick generator
    S_DRAW_A,   // draw: step a
    S_DRAW_B,   // draw: step b
    S_INDEX,    // draw: index = TABLE_DEPTH * pick / 134456
    S_READ,     // table read in flight
    S_OUT       // present the old entry and write the new one
  } state_t;

  state_t               state;
  logic                 launched;
  logic [GEN_A_W-1:0]   gen_a;
  logic [GEN_B_W-1:0]   gen_b;
  logic [GEN_P_W-1:0]   gen_pick;
  logic                 is_seeded;
  logic [ACC_W-1:0]     seed_val;
  logic                 did_reseed;
  logic [IDX_W-1:0]     fill_idx;
  logic [IDX_W-1:0]     pick_idx;
  logic                 out_valid;
  logic [GEN_A_W-1:0]   out_coarse;
  logic [GEN_B_W-1:0]   out_fine;
  logic                 out_reseeded;

  logic                 op_state;
  logic                 unit_start;
  lcg_op_t              unit_op;
  lcg_res_t             unit_res;
  logic                 in_fire;
  logic                 out_free;
  logic                 need_reseed;
  logic [ACC_W-1:0]     seed_biased;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [ENTRY_W-1:0]   ram_wdata;
  logic [ENTRY_W-1:0]   ram_rdata;

  assign in_ch.ready = (state == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid || out_ch.ready;

  // A negative seed or an unseeded block forces a reseed before the draw.
  assign need_reseed = in_ch.seed[SEED_W-1] || !is_seeded;

  // 150889 - seed, lifted by a multiple of 714025 so the remainder comes out
  // nonnegative; the true value always fits in 32 unsigned bits.
  assign seed_biased = ACC_W'(INC_A) + SEED_BIAS
                       - {{(ACC_W - SEED_W){in_ch.seed[SEED_W-1]}}, in_ch.seed};

  assign op_state   = (state inside {S_SEED, S_A1, S_BMOD, S_A2, S_PMOD, S_FILL_B,
                                     S_FILL_A, S_PICK, S_DRAW_A, S_DRAW_B, S_INDEX});
  assign unit_start = op_state && !launched;

  // Operand selection for the shared unit.
  always_comb begin
    unit_op = '0;
    case (state)
      S_SEED: begin
        unit_op.x       = seed_val;
        unit_op.mul     = MUL_W'(1);
        unit_op.modulus = MOD_A;
        unit_op.recip   = RCP_A;
      end
      S_A1, S_A2, S_FILL_A, S_DRAW_A: begin
        unit_op.x       = ACC_W'(gen_a);
        unit_op.mul     = MUL_A;
        unit_op.inc     = INC_A;
        unit_op.modulus = MOD_A;
        unit_op.recip   = RCP_A;
      end
      S_BMOD: begin
        unit_op.x       = ACC_W'(gen_a);
        unit_op.mul     = MUL_W'(1);
        unit_op.modulus = MOD_B;
        unit_op.recip   = RCP_B;
      end
      S_PMOD: begin
        unit_op.x       = ACC_W'(gen_a);
        unit_op.mul     = MUL_W'(1);
        unit_op.modulus = MOD_P;
        unit_op.recip   = RCP_P;
      end
      S_FILL_B, S_DRAW_B: begin
        unit_op.x       = ACC_W'(gen_b);
        unit_op.mul     = MUL_B;
        unit_op.inc     = INC_B;
        unit_op.modulus = MOD_B;
        unit_op.recip   = RCP_B;
      end
      S_PICK: begin
        unit_op.x       = ACC_W'(gen_pick);
        unit_op.mul     = MUL_P;
        unit_op.inc     = INC_P;
        unit_op.modulus = MOD_P;
        unit_op.recip   = RCP_P;
      end
      S_INDEX: begin
        // The quotient of this job is the table index.
        unit_op.x       = ACC_W'(gen_pick);
        unit_op.mul     = MUL_W'(TABLE_DEPTH);
        unit_op.modulus = MOD_P;
        unit_op.recip   = RCP_P;
      end
      default: unit_op = '0;
    endcase
  end

  stlu_lcg_unit u_lcg (
    .clk   (clk),
    .rst   (rst),
    .start (unit_start),
    .op    (unit_op),
    .res   (unit_res)
  );

  // The table is written during a fill and when a draw retires; a draw writes
  // the same entry it reads, in the cycle that the old contents go to the output register.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = fill_idx;
    ram_wdata = {{GEN_B_W{1'b0}}, unit_res.rem};
    if (state == S_FILL_A && unit_res.done) begin
      ram_we = 1'b1;
    end else if (state == S_OUT && out_free) begin
      ram_we    = 1'b1;
      ram_waddr = pick_idx;
      ram_wdata = {gen_b, gen_a};
    end
  end

  stlu_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (pick_idx),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      launched  <= 1'b0;
      is_seeded <= 1'b0;
      out_valid <= 1'b0;
      gen_a     <= '0;
      gen_b     <= '0;
      gen_pick  <= '0;
    end else begin
      // A new result refills the output register in the same cycle that the
      // old one is taken.
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ch.valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      if (unit_start) begin
        launched <= 1'b1;
      end else if (unit_res.done) begin
        launched <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (in_ch.command) begin
              is_seeded <= 1'b0;
            end else begin
              seed_val   <= seed_biased;
              did_reseed <= need_reseed;
              state      <= need_reseed ? S_SEED : S_PICK;
            end
          end
        end
        S_SEED: begin
          if (unit_res.done) begin
            gen_a <= unit_res.rem;
            state <= S_A1;
          end
        end
        S_A1: begin
          if (unit_res.done) begin
            gen_a <= unit_res.rem;
            state <= S_BMOD;
          end
        end
        S_BMOD: begin
          if (unit_res.done) begin
            gen_b <= unit_res.rem[GEN_B_W-1:0];
            state <= S_A2;
          end
        end
        S_A2: begin
          if (unit_res.done) begin
            gen_a <= unit_res.rem;
            state <= S_PMOD;
          end
        end
        S_PMOD: begin
          if (unit_res.done) begin
            gen_pick <= unit_res.rem[GEN_P_W-1:0];
            fill_idx <= '0;
            state    <= S_FILL_B;
          end
        end
        S_FILL_B: begin
          if (unit_res.done) begin
            gen_b <= unit_res.rem[GEN_B_W-1:0];
            state <= S_FILL_A;
          end
        end
        S_FILL_A: begin
          if (unit_res.done) begin
            gen_a <= unit_res.rem;
            if (fill_idx == LAST_IDX) begin
              is_seeded <= 1'b1;
              state     <= S_PICK;
            end else begin
              fill_idx <= fill_idx + IDX_W'(1);
              state    <= S_FILL_B;
            end
          end
        end
        S_PICK: begin
          if (unit_res.done) begin
            gen_pick <= unit_res.rem[GEN_P_W-1:0];
            state    <= S_DRAW_A;
          end
        end
        S_DRAW_A: begin
          if (unit_res.done) begin
            gen_a <= unit_res.rem;
            state <= S_DRAW_B;
          end
        end
        S_DRAW_B: begin
          if (unit_res.done) begin
            gen_b <= unit_res.rem[GEN_B_W-1:0];
            state <= S_INDEX;
          end
        end
        S_INDEX: begin
          if (unit_res.done) begin
            pick_idx <= unit_res.quo[IDX_W-1:0];
            state    <= S_READ;
          end
        end
        S_READ: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_coarse   <= ram_rdata[GEN_A_W-1:0];
            out_fine     <= ram_rdata[ENTRY_W-1:GEN_A_W];
            out_reseeded <= did_reseed;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid    = out_valid;
  assign out_ch.coarse   = out_coarse;
  assign out_ch.fine     = out_fine;
  assign out_ch.reseeded = out_reseeded;

  // The sequencer never hands the shared unit a new job while one is running.
  a_no_overlap : assert property (@(posedge clk) disable iff (rst)
    unit_start |-> !unit_res.busy)
    else $error("shared unit started while busy");

  // Every table write stays inside the table.
  a_write_in_range : assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (ram_waddr <= LAST_IDX))
    else $error("table write beyond last entry");

  // A result can only appear once the table has been filled.
  a_seeded_on_result : assert property (@(posedge clk) disable iff (rst)
    $rose(out_ch.valid) |-> is_seeded)
    else $error("result produced from an unseeded table");

  // A draw index computed by the shared unit always lands inside the table.
  a_index_in_range : assert property (@(posedge clk) disable iff (rst)
    (state == S_INDEX && unit_res.done) |-> (unit_res.quo <= QUO_W'(TABLE_DEPTH - 1)))
    else $error("draw index out of range");

endmodule
